>>> sv/bclt_pkg.sv
package bclt_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int TICK_W = 16;
  localparam int REP_W = 8;
  localparam int CFG_W = 16;
  localparam int MAX_RES = 3;
  localparam int CNT_W = $clog2(MAX_RES + 1);

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [REP_W-1:0] REP_MAX = {REP_W{1'b1}};
  localparam logic [CFG_W-1:0] DBL_RESET = CFG_W'(100);
  localparam logic [CFG_W-1:0] LONG_RESET = CFG_W'(1000);

  // Only button 1 reports a plain click in addition to click-any.
  localparam logic [1:0] CLICK_BUTTON = 2'd1;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_ABORT   = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_PRESSED     = 3'd0,
    EV_UNPRESSED   = 3'd1,
    EV_CLICKED     = 3'd2,
    EV_CLICKED_ANY = 3'd3,
    EV_LONG        = 3'd4
  } event_t;

  typedef enum logic {
    REG_DOUBLE_CLICK = 1'b0,
    REG_LONGPRESS    = 1'b1
  } reg_idx_t;

  // Per-button status handed from a button unit to the top level.
  typedef struct packed {
    logic             long_fire;
    logic             was_held;
    logic [REP_W-1:0] rep_next;
  } btn_status_t;

  typedef struct packed {
    event_t           ev;
    logic [1:0]       btn;
    logic [REP_W-1:0] rep;
    logic             last;
  } res_t;

endpackage

>>> sv/bclt_if.sv
interface bclt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] button;

  modport source (output valid, output cmd, output button, input ready);
  modport sink (input valid, input cmd, input button, output ready);
endinterface

interface bclt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] which_button;
  logic [7:0] repeat_count;
  logic       last;

  modport source (output valid, output event_res, output which_button,
                  output repeat_count, output last, input ready);
  modport sink (input valid, input event_res, input which_button,
                input repeat_count, input last, output ready);
endinterface

>>> sv/bclt_button.sv
module bclt_button (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           sel,
  input  bclt_pkg::cmd_t                 cmd,
  input  logic [bclt_pkg::CFG_W-1:0]     double_click_ticks,
  input  logic [bclt_pkg::CFG_W-1:0]     longpress_ticks,
  output bclt_pkg::btn_status_t          status
);

  logic                          held;
  logic                          timer_running;
  logic [bclt_pkg::TICK_W-1:0]   hold_ticks;
  logic                          click_seen;
  logic [bclt_pkg::TICK_W-1:0]   ticks_since_release;
  logic [bclt_pkg::REP_W-1:0]    repeats;

  logic                          tick;
  logic [bclt_pkg::TICK_W-1:0]   hold_inc;
  logic [bclt_pkg::TICK_W-1:0]   tsr_inc;

  assign tick = (cmd == bclt_pkg::CMD_TICK);
  assign hold_inc = (hold_ticks == bclt_pkg::TICK_MAX) ? hold_ticks : hold_ticks + 1'b1;
  assign tsr_inc = (ticks_since_release == bclt_pkg::TICK_MAX) ?
                   ticks_since_release : ticks_since_release + 1'b1;

  always_comb begin
    status.long_fire = tick && timer_running && (hold_inc >= longpress_ticks);
    status.was_held = held;
    if (click_seen && (ticks_since_release < double_click_ticks)) begin
      status.rep_next = (repeats == bclt_pkg::REP_MAX) ? repeats : repeats + 1'b1;
    end else begin
      status.rep_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      timer_running <= 1'b0;
      hold_ticks <= '0;
      click_seen <= 1'b0;
      ticks_since_release <= '0;
      repeats <= '0;
    end else if (accept) begin
      if (tick) begin
        ticks_since_release <= tsr_inc;
        if (timer_running) begin
          hold_ticks <= hold_inc;
          if (status.long_fire) begin
            timer_running <= 1'b0;
          end
        end
      end else if (sel) begin
        case (cmd)
          bclt_pkg::CMD_PRESS: begin
            held <= 1'b1;
            timer_running <= 1'b1;
            hold_ticks <= '0;
          end
          bclt_pkg::CMD_RELEASE: begin
            repeats <= status.rep_next;
            click_seen <= 1'b1;
            ticks_since_release <= '0;
            held <= 1'b0;
            timer_running <= 1'b0;
            hold_ticks <= '0;
          end
          default: begin
            held <= 1'b0;
            timer_running <= 1'b0;
            hold_ticks <= '0;
          end
        endcase
      end
    end
  end

endmodule

>>> sv/button_click_longpress_tracker.sv
// A transaction's results are written into the result batch, then moved one by one to the output register.
// Throughput: one input per cycle when each input yields at most one result and the
// consumer does not stall; an input yielding n results holds the result batch until
// the output register has drained them, one result per cycle while results are taken.
// Reset: synchronous, active high; clears all button state, the result batch and
// the output register, and restores the reset values of both configuration registers.
module button_click_longpress_tracker (
  input  logic                        clk,
  input  logic                        rst,
  bclt_in_if.sink                     in_ch,
  bclt_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bclt_pkg::CFG_W-1:0]  cfg_data
);

  // Configuration registers. They must be written only while the block is idle,
  // so no shadowing is needed; the block itself does not enforce this.
  logic [bclt_pkg::CFG_W-1:0] double_click_ticks;
  logic [bclt_pkg::CFG_W-1:0] longpress_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_click_ticks <= bclt_pkg::DBL_RESET;
      longpress_ticks <= bclt_pkg::LONG_RESET;
    end else if (cfg_we) begin
      case (bclt_pkg::reg_idx_t'(cfg_index))
        bclt_pkg::REG_DOUBLE_CLICK: double_click_ticks <= cfg_data;
        bclt_pkg::REG_LONGPRESS:    longpress_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result batch: holds the results of one accepted input in order, with
  // the head in slot zero. It feeds a single output register, which parts
  // the input side from a stalled consumer.
  bclt_pkg::res_t                 batch [bclt_pkg::MAX_RES];
  logic [bclt_pkg::CNT_W-1:0]     batch_cnt;
  bclt_pkg::res_t                 out_res;
  logic                           out_valid;

  logic                           out_load;
  logic                           accept;
  bclt_pkg::cmd_t                 cmd;
  logic                           btn_ok;

  // The head moves to the output register whenever that register is empty
  // or is being taken in this cycle.
  assign out_load = (batch_cnt != '0) && (!out_valid || out_ch.ready);

  // A new transaction is taken whenever the batch will be empty after this
  // edge, so a single-result stream flows at one transaction per cycle while results are taken.
  assign in_ch.ready = (batch_cnt == '0) ||
                       ((batch_cnt == bclt_pkg::CNT_W'(1)) && out_load);
  assign accept = in_ch.valid && in_ch.ready;
  assign cmd = bclt_pkg::cmd_t'(in_ch.cmd);
  assign btn_ok = (in_ch.button < 2'(bclt_pkg::NUM_BUTTONS));

  // One unit per button keeps its counters and reports the status its events are built from.
  bclt_pkg::btn_status_t status [bclt_pkg::NUM_BUTTONS];

  for (genvar g = 0; g < bclt_pkg::NUM_BUTTONS; g++) begin : g_btn
    bclt_button u_button (
      .clk                (clk),
      .rst                (rst),
      .accept             (accept),
      .sel                (btn_ok && (in_ch.button == 2'(g))),
      .cmd                (cmd),
      .double_click_ticks (double_click_ticks),
      .longpress_ticks    (longpress_ticks),
      .status             (status[g])
    );
  end

  // Build the list of results that the current input causes.
  bclt_pkg::res_t             lst [bclt_pkg::MAX_RES];
  logic [bclt_pkg::CNT_W-1:0] lst_n;
  bclt_pkg::btn_status_t      sel_st;

  always_comb begin
    sel_st = status[in_ch.button < 2'(bclt_pkg::NUM_BUTTONS) ?
                    in_ch.button : 2'd0];
    lst_n = '0;
    for (int k = 0; k < bclt_pkg::MAX_RES; k++) begin
      lst[k] = '{ev: bclt_pkg::EV_PRESSED, btn: 2'd0, rep: '0, last: 1'b0};
    end
    if (cmd == bclt_pkg::CMD_TICK) begin
      // Long presses are reported in ascending button order.
      for (int i = 0; i < bclt_pkg::NUM_BUTTONS; i++) begin
        if (status[i].long_fire) begin
          lst[lst_n[1:0]] = '{ev: bclt_pkg::EV_LONG, btn: 2'(i), rep: '0, last: 1'b0};
          lst_n = lst_n + 1'b1;
        end
      end
    end else if (btn_ok) begin
      if (cmd == bclt_pkg::CMD_PRESS) begin
        lst[0] = '{ev: bclt_pkg::EV_PRESSED, btn: in_ch.button, rep: '0, last: 1'b0};
        lst_n = bclt_pkg::CNT_W'(1);
      end else if (cmd == bclt_pkg::CMD_RELEASE) begin
        lst[0] = '{ev: bclt_pkg::EV_UNPRESSED, btn: in_ch.button, rep: '0, last: 1'b0};
        lst_n = bclt_pkg::CNT_W'(1);
        // A click is only reported when the button was actually held.
        if (sel_st.was_held) begin
          if (in_ch.button == bclt_pkg::CLICK_BUTTON) begin
            lst[lst_n[1:0]] = '{ev: bclt_pkg::EV_CLICKED, btn: in_ch.button,
                                rep: sel_st.rep_next, last: 1'b0};
            lst_n = lst_n + 1'b1;
          end
          lst[lst_n[1:0]] = '{ev: bclt_pkg::EV_CLICKED_ANY, btn: in_ch.button,
                              rep: sel_st.rep_next, last: 1'b0};
          lst_n = lst_n + 1'b1;
        end
      end
    end
    for (int k = 0; k < bclt_pkg::MAX_RES; k++) begin
      lst[k].last = (bclt_pkg::CNT_W'(k + 1) == lst_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_cnt <= '0;
    end else if (accept) begin
      batch_cnt <= lst_n;
    end else if (out_load) begin
      batch_cnt <= batch_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      batch <= lst;
    end else if (out_load) begin
      for (int k = 0; k < bclt_pkg::MAX_RES - 1; k++) begin
        batch[k] <= batch[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= batch[0];
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.event_res = out_res.ev;
  assign out_ch.which_button = out_res.btn;
  assign out_ch.repeat_count = out_res.rep;
  assign out_ch.last = out_res.last;

endmodule

>>> tb/tb.sv
module tb;

  // The watchdog ends the run after this many cycles in which neither channel
  // completes a transaction. The longest deliberate stall is the output
  // hold-off of the backpressure test, which is well below this.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles allowed after the last expected result before the tracker is
  // treated as idle, since inputs that cause no result may still be in flight.
  localparam int PIPE_SLACK = 6;
  localparam int RANDOM_ITEMS = 96;
  localparam int OUT_HOLD_CYCLES = 400;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic                        cfg_index;
  logic [bclt_pkg::CFG_W-1:0]  cfg_data;

  bclt_in_if  in_ch();
  bclt_out_if out_ch();

  button_click_longpress_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the tracker state and its two registers. It is advanced
  // once for every input transaction at the clock edge that accepts it.
  logic [bclt_pkg::CFG_W-1:0]  dbl_window;
  logic [bclt_pkg::CFG_W-1:0]  long_limit;
  logic                        is_held       [bclt_pkg::NUM_BUTTONS];
  logic                        long_armed    [bclt_pkg::NUM_BUTTONS];
  logic [bclt_pkg::TICK_W-1:0] hold_count    [bclt_pkg::NUM_BUTTONS];
  logic                        released_once [bclt_pkg::NUM_BUTTONS];
  logic [bclt_pkg::TICK_W-1:0] since_release [bclt_pkg::NUM_BUTTONS];
  logic [bclt_pkg::REP_W-1:0]  repeat_run    [bclt_pkg::NUM_BUTTONS];

  // Button events the tracker still owes us, oldest first.
  bclt_pkg::res_t expected_events[$];

  int in_idle_pct = 27;
  int out_idle_pct = 27;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int long_seen = 0;
  int max_repeat_seen = 0;
  int settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [bclt_pkg::TICK_W-1:0] tick_up(logic [bclt_pkg::TICK_W-1:0] v);
    return (v == bclt_pkg::TICK_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bclt_pkg::res_t make_event(bclt_pkg::event_t e, int btn,
                                                logic [bclt_pkg::REP_W-1:0] rep);
    bclt_pkg::res_t r;
    r.ev = e;
    r.btn = btn[1:0];
    r.rep = rep;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out the events caused by one accepted transaction and queues them.
  // Only the final event of a transaction carries the last flag.
  task automatic track_buttons(bclt_pkg::cmd_t c, logic [1:0] b);
    bclt_pkg::res_t batch[$];
    logic was_held;
    if (c == bclt_pkg::CMD_TICK) begin
      // A tick ages every button; long presses come out in button order.
      for (int i = 0; i < bclt_pkg::NUM_BUTTONS; i++) begin
        since_release[i] = tick_up(since_release[i]);
        if (long_armed[i]) begin
          hold_count[i] = tick_up(hold_count[i]);
          if (hold_count[i] >= long_limit) begin
            long_armed[i] = 1'b0;
            batch.push_back(make_event(bclt_pkg::EV_LONG, i, '0));
          end
        end
      end
    end else if (b < bclt_pkg::NUM_BUTTONS) begin
      case (c)
        bclt_pkg::CMD_PRESS: begin
          is_held[b] = 1'b1;
          long_armed[b] = 1'b1;
          hold_count[b] = '0;
          batch.push_back(make_event(bclt_pkg::EV_PRESSED, b, '0));
        end
        bclt_pkg::CMD_RELEASE: begin
          was_held = is_held[b];
          // The repeat run grows only when the previous release of this
          // button was strictly inside the double-click window.
          if (released_once[b] && since_release[b] < dbl_window) begin
            if (repeat_run[b] != bclt_pkg::REP_MAX) repeat_run[b] = repeat_run[b] + 1'b1;
          end else begin
            repeat_run[b] = '0;
          end
          released_once[b] = 1'b1;
          since_release[b] = '0;
          is_held[b] = 1'b0;
          long_armed[b] = 1'b0;
          hold_count[b] = '0;
          batch.push_back(make_event(bclt_pkg::EV_UNPRESSED, b, '0));
          if (was_held) begin
            if (b == bclt_pkg::CLICK_BUTTON)
              batch.push_back(make_event(bclt_pkg::EV_CLICKED, b, repeat_run[b]));
            batch.push_back(make_event(bclt_pkg::EV_CLICKED_ANY, b, repeat_run[b]));
          end
        end
        default: begin
          is_held[b] = 1'b0;
          long_armed[b] = 1'b0;
          hold_count[b] = '0;
        end
      endcase
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) expected_events.push_back(batch[k]);
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Offers one transaction, idling first at random. Valid is left high after
  // acceptance so that back-to-back transactions never lower and raise it in
  // the same time step; settle() drops it when a stretch of traffic ends.
  task automatic send(bclt_pkg::cmd_t c, logic [1:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.button <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    track_buttons(c, b);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    // The button field means nothing on a tick, so it is randomized.
    repeat (n) send(bclt_pkg::CMD_TICK, 2'($urandom_range(0, 3)));
  endtask

  // Stops offering input and waits until every owed event has arrived and
  // the pipeline has had time to empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; write enable stays high
  // across the pair. Only called while the tracker is idle.
  task automatic set_config(logic [bclt_pkg::CFG_W-1:0] window,
                            logic [bclt_pkg::CFG_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= bclt_pkg::REG_DOUBLE_CLICK;
    cfg_data <= window;
    @(posedge clk);
    cfg_index <= bclt_pkg::REG_LONGPRESS;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    dbl_window = window;
    long_limit = limit;
    settings_used++;
  endtask

  // Reset values of the registers, plain clicks on buttons 0 and 1, a quick
  // repeat, a release with nothing held, aborts and invalid button numbers.
  task automatic test_defaults();
    send(bclt_pkg::CMD_PRESS, 2'd0);
    send(bclt_pkg::CMD_RELEASE, 2'd0);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send(bclt_pkg::CMD_RELEASE, 2'd1);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send(bclt_pkg::CMD_TICK, 2'd0);
    send(bclt_pkg::CMD_RELEASE, 2'd1);
    send(bclt_pkg::CMD_RELEASE, 2'd2);
    send(bclt_pkg::CMD_PRESS, 2'd2);
    send(bclt_pkg::CMD_ABORT, 2'd2);
    send(bclt_pkg::CMD_RELEASE, 2'd2);
    send(bclt_pkg::CMD_ABORT, 2'd0);
    send(bclt_pkg::CMD_PRESS, 2'd3);
    send(bclt_pkg::CMD_RELEASE, 2'd3);
    send(bclt_pkg::CMD_ABORT, 2'd3);
    send(bclt_pkg::CMD_TICK, 2'd3);
    settle();
  endtask

  // Long presses on all three buttons in one tick, an abort that stops the
  // count, a zero limit that fires on the first tick, and the limit of one.
  task automatic test_long_press();
    set_config(16'd5, 16'd3);
    send(bclt_pkg::CMD_PRESS, 2'd2);
    send(bclt_pkg::CMD_PRESS, 2'd0);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send_ticks(4);
    send(bclt_pkg::CMD_PRESS, 2'd0);
    send(bclt_pkg::CMD_TICK, 2'd1);
    send(bclt_pkg::CMD_ABORT, 2'd0);
    send_ticks(3);
    settle();
    set_config(16'd5, 16'd0);
    send(bclt_pkg::CMD_PRESS, 2'd2);
    send(bclt_pkg::CMD_TICK, 2'd2);
    settle();
    set_config(16'd5, 16'd1);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send(bclt_pkg::CMD_TICK, 2'd0);
    send(bclt_pkg::CMD_RELEASE, 2'd1);
    settle();
  endtask

  // Window of one tick: a release on the same tick repeats, one a tick later
  // does not. A zero window never counts a repeat.
  task automatic test_double_click();
    set_config(16'd1, 16'd1000);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send(bclt_pkg::CMD_RELEASE, 2'd1);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send(bclt_pkg::CMD_RELEASE, 2'd1);
    send(bclt_pkg::CMD_TICK, 2'd0);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send(bclt_pkg::CMD_RELEASE, 2'd1);
    settle();
    set_config(16'd0, 16'd1000);
    send(bclt_pkg::CMD_PRESS, 2'd0);
    send(bclt_pkg::CMD_RELEASE, 2'd0);
    send(bclt_pkg::CMD_PRESS, 2'd0);
    send(bclt_pkg::CMD_RELEASE, 2'd0);
    settle();
  endtask

  // Releases with nothing held still advance the repeat run, so a burst of
  // them pushes the count into saturation; a final click on button 1 then
  // reports the saturated count. This is also the long stretch with no
  // idling on either side.
  task automatic test_repeat_saturation();
    set_config(16'hFFFF, 16'hFFFF);
    in_idle_pct = 0;
    out_idle_pct = 0;
    send(bclt_pkg::CMD_PRESS, 2'd1);
    repeat (258) send(bclt_pkg::CMD_RELEASE, 2'd1);
    send(bclt_pkg::CMD_PRESS, 2'd1);
    send(bclt_pkg::CMD_RELEASE, 2'd1);
    settle();
    in_idle_pct = 27;
    out_idle_pct = 27;
  endtask

  // Random traffic in four phases with different register settings. Most of
  // it is press, ticks, release sequences, often followed by a second click
  // or with another button pressed in between; the rest is loose ticks and
  // noise that includes invalid buttons and unmatched commands.
  task automatic test_random();
    int phase_start;
    int pick;
    logic [1:0] btn;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_config(16'd1, 16'd1);
          in_idle_pct = 27;
          out_idle_pct = 27;
        end
        1: begin
          // No idling on either side.
          set_config(bclt_pkg::CFG_W'($urandom_range(2, 12)),
                     bclt_pkg::CFG_W'($urandom_range(2, 20)));
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
        2: begin
          set_config(bclt_pkg::CFG_W'($urandom_range(2, 12)),
                     bclt_pkg::CFG_W'($urandom_range(2, 20)));
          in_idle_pct = 27;
          out_idle_pct = 27;
        end
        default: begin
          set_config(16'hFFFF, bclt_pkg::CFG_W'($urandom_range(1, 8)));
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
        pick = $urandom_range(0, 99);
        btn = 2'($urandom_range(0, 2));
        if (pick < 60) begin
          send(bclt_pkg::CMD_PRESS, btn);
          if ($urandom_range(0, 3) == 0)
            send(bclt_pkg::CMD_PRESS, 2'($urandom_range(0, 2)));
          send_ticks($urandom_range(0, (long_limit > 12) ? 24 : 2 * long_limit + 1));
          if ($urandom_range(0, 9) == 0) send(bclt_pkg::CMD_ABORT, btn);
          else send(bclt_pkg::CMD_RELEASE, btn);
          if ($urandom_range(0, 2) == 0) begin
            send_ticks($urandom_range(0, 3));
            send(bclt_pkg::CMD_PRESS, btn);
            send(bclt_pkg::CMD_RELEASE, btn);
          end
        end else if (pick < 80) begin
          send_ticks($urandom_range(1, 6));
        end else begin
          send(bclt_pkg::cmd_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        end
      end
      settle();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering clicks, so the result path fills and the input stalls.
  task automatic test_backpressure();
    set_config(16'd50, 16'd4);
    in_idle_pct = 0;
    hold_left = OUT_HOLD_CYCLES;
    repeat (10) begin
      send(bclt_pkg::CMD_PRESS, 2'($urandom_range(0, 2)));
      send(bclt_pkg::CMD_RELEASE, 2'($urandom_range(0, 2)));
      if ($urandom_range(0, 2) == 0) send(bclt_pkg::CMD_TICK, 2'd0);
    end
    settle();
    in_idle_pct = 27;
  endtask

  // Receiver: ready is random unless a hold-off is running, in which case
  // this process counts the hold-off down one cycle at a time.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Result checker: every accepted result is compared with the oldest
  // owed event, field by field.
  always @(posedge clk) begin : result_check
    bclt_pkg::res_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (out_ch.event_res == bclt_pkg::EV_LONG) long_seen++;
      if (out_ch.repeat_count > max_repeat_seen) max_repeat_seen = out_ch.repeat_count;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result: event %0d button %0d repeat %0d",
                                  out_ch.event_res, out_ch.which_button,
                                  out_ch.repeat_count));
      end else begin
        want = expected_events.pop_front();
        if (out_ch.event_res !== want.ev)
          report_mismatch($sformatf("event %0d, expected %s", out_ch.event_res,
                                    want.ev.name()));
        if (out_ch.which_button !== want.btn)
          report_mismatch($sformatf("button %0d, expected %0d", out_ch.which_button,
                                    want.btn));
        if (out_ch.repeat_count !== want.rep)
          report_mismatch($sformatf("repeat count %0d, expected %0d",
                                    out_ch.repeat_count, want.rep));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last flag %0b, expected %0b", out_ch.last,
                                    want.last));
      end
    end
  end

  // Watchdog: a run that stops moving transactions on both channels has hung.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= bclt_pkg::CMD_PRESS;
    in_ch.button <= 2'd0;
    cfg_we <= 1'b0;
    cfg_index <= bclt_pkg::REG_DOUBLE_CLICK;
    cfg_data <= '0;
    dbl_window = bclt_pkg::DBL_RESET;
    long_limit = bclt_pkg::LONG_RESET;
    for (int i = 0; i < bclt_pkg::NUM_BUTTONS; i++) begin
      is_held[i] = 1'b0;
      long_armed[i] = 1'b0;
      hold_count[i] = '0;
      released_once[i] = 1'b0;
      since_release[i] = '0;
      repeat_run[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_long_press();
    test_double_click();
    test_repeat_saturation();
    test_random();
    test_backpressure();

    $display("Covered %0d input transactions and %0d results over %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("Saw %0d long presses; highest repeat count %0d.", long_seen, max_repeat_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bclt_pkg.sv
sv/bclt_if.sv
sv/bclt_button.sv
sv/button_click_longpress_tracker.sv
tb/tb.sv
